// ===== rtl/tctd_pkg.sv =====
// ----------------------------------------------------------------------------
// tctd_pkg
// shared types and constants of the time-of-day unit
// ----------------------------------------------------------------------------
package tctd_pkg;

   localparam int unsigned COUNT_W          = 64;
   localparam int unsigned SEC_W            = 63;
   localparam int unsigned USEC_W           = 20;
   localparam int unsigned HZ_W             = 30;
   localparam int unsigned QUOT_W           = 45;
   localparam int unsigned HALF_W           = 32;
   localparam int unsigned PROD_W           = COUNT_W + QUOT_W;
   localparam int unsigned USEC_SHIFT       = 30;
   localparam int unsigned USEC_PER_SEC     = 1000000;
   localparam int unsigned TICK_HZ_DEFAULT  = 24000000;

   typedef enum logic {
      CMD_READ = 1'b0,
      CMD_SET  = 1'b1
   } command_type;

   typedef struct packed {
      command_type         command;
      logic [COUNT_W-1:0]  counter_now;
      logic [SEC_W-1:0]    set_seconds;
      logic [USEC_W-1:0]   set_microseconds;
   } req_type;

   typedef struct packed {
      logic [SEC_W-1:0]    seconds;
      logic [USEC_W-1:0]   microseconds;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  elapsed;
      logic [SEC_W-1:0]    base_seconds;
      logic [USEC_W-1:0]   base_microseconds;
   } elapsed_type;

   typedef struct packed {
      logic [QUOT_W-1:0]   quotient;
      logic [HZ_W-1:0]     remainder;
      logic [SEC_W-1:0]    base_seconds;
      logic [USEC_W-1:0]   base_microseconds;
   } split_type;

   typedef struct packed {
      logic [QUOT_W-1:0]   quotient;
      logic [USEC_W-1:0]   sub_microseconds;
      logic [SEC_W-1:0]    base_seconds;
      logic [USEC_W-1:0]   base_microseconds;
   } sub_type;

endpackage

// ===== rtl/tctd_capture.sv =====
// ----------------------------------------------------------------------------
// tctd_capture
// input register, base time and reference count, elapsed tick count
// ----------------------------------------------------------------------------
module tctd_capture (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tctd_pkg::req_type      req_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tctd_pkg::elapsed_type  out_data
);

   logic                             valid_ff;
   logic                             valid_in;
   logic                             ready;
   logic                             accept;
   logic                             is_set;
   logic [tctd_pkg::SEC_W-1:0]       base_seconds_ff;
   logic [tctd_pkg::SEC_W-1:0]       base_seconds_in;
   logic [tctd_pkg::USEC_W-1:0]      base_microseconds_ff;
   logic [tctd_pkg::USEC_W-1:0]      base_microseconds_in;
   logic [tctd_pkg::COUNT_W-1:0]     reference_count_ff;
   logic [tctd_pkg::COUNT_W-1:0]     reference_count_in;
   tctd_pkg::elapsed_type            data_ff;
   tctd_pkg::elapsed_type            data_in;

   assign ready     = !valid_ff || out_ready;
   assign req_stall = !ready;
   assign accept    = req_valid && ready;
   assign is_set    = (req_data.command == tctd_pkg::CMD_SET);

   always_comb begin
      valid_in             = ready ? (req_valid && !is_set) : valid_ff;
      base_seconds_in      = base_seconds_ff;
      base_microseconds_in = base_microseconds_ff;
      reference_count_in   = reference_count_ff;
      if (accept && is_set) begin
         base_seconds_in      = req_data.set_seconds;
         base_microseconds_in = req_data.set_microseconds;
         reference_count_in   = req_data.counter_now;
      end
      data_in.elapsed           = req_data.counter_now - reference_count_ff;
      data_in.base_seconds      = base_seconds_ff;
      data_in.base_microseconds = base_microseconds_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff             <= 1'b0;
         base_seconds_ff      <= '0;
         base_microseconds_ff <= '0;
         reference_count_ff   <= '0;
      end else begin
         valid_ff             <= valid_in;
         base_seconds_ff      <= base_seconds_in;
         base_microseconds_ff <= base_microseconds_in;
         reference_count_ff   <= reference_count_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept && !is_set) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/tctd_divide.sv =====
// ----------------------------------------------------------------------------
// tctd_divide
// elapsed ticks to whole seconds and tick remainder by reciprocal multiply
// ----------------------------------------------------------------------------
module tctd_divide #(
   parameter int unsigned TICK_HZ = tctd_pkg::TICK_HZ_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tctd_pkg::elapsed_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tctd_pkg::split_type    out_data
);

   localparam int unsigned HW  = tctd_pkg::HALF_W;
   localparam int unsigned QW  = tctd_pkg::QUOT_W;
   localparam int unsigned RHW = tctd_pkg::QUOT_W - tctd_pkg::HALF_W;
   localparam int unsigned PW  = tctd_pkg::PROD_W;
   localparam logic [127:0] RecipFull = (128'd1 << tctd_pkg::COUNT_W) / 128'(TICK_HZ);
   localparam logic [QW-1:0] Recip    = RecipFull[QW-1:0];
   localparam logic [tctd_pkg::HZ_W-1:0] HzVal = tctd_pkg::HZ_W'(TICK_HZ);

   // stage 1: partial products
   logic                       s1_valid_ff, s1_valid_in, s1_ready;
   logic [2*HW-1:0]            s1_pp0_ff, s1_pp2_ff;
   logic [HW+RHW-1:0]          s1_pp1_ff, s1_pp3_ff;
   tctd_pkg::elapsed_type      s1_data_ff;
   // stage 2: quotient estimate
   logic                       s2_valid_ff, s2_valid_in, s2_ready;
   logic [PW-1:0]              s2_sum;
   logic [QW-1:0]              s2_quot_ff;
   tctd_pkg::elapsed_type      s2_data_ff;
   // stage 3: low word of quotient times rate
   logic                       s3_valid_ff, s3_valid_in, s3_ready;
   logic [HW+tctd_pkg::HZ_W-1:0] s3_prod;
   logic [HW-1:0]              s3_prod_ff;
   logic [QW-1:0]              s3_quot_ff;
   tctd_pkg::elapsed_type      s3_data_ff;
   // stage 4: remainder and correction
   logic                       s4_valid_ff, s4_valid_in, s4_ready;
   logic [HW-1:0]              s4_rem_est;
   logic                       s4_over;
   logic [HW-1:0]              s4_rem;
   tctd_pkg::split_type        s4_data_in;
   tctd_pkg::split_type        s4_data_ff;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid    : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_comb begin
      s2_sum = PW'(s1_pp0_ff)
             + (PW'(s1_pp1_ff) << HW)
             + (PW'(s1_pp2_ff) << HW)
             + (PW'(s1_pp3_ff) << (2 * HW));
      s3_prod    = (HW + tctd_pkg::HZ_W)'(s2_quot_ff[HW-1:0])
                 * (HW + tctd_pkg::HZ_W)'(HzVal);
      s4_rem_est = s3_data_ff.elapsed[HW-1:0] - s3_prod_ff;
      s4_over    = (s4_rem_est >= HW'(HzVal));
      s4_rem     = s4_over ? (s4_rem_est - HW'(HzVal)) : s4_rem_est;
      s4_data_in.quotient          = s3_quot_ff + QW'(s4_over);
      s4_data_in.remainder         = s4_rem[tctd_pkg::HZ_W-1:0];
      s4_data_in.base_seconds      = s3_data_ff.base_seconds;
      s4_data_in.base_microseconds = s3_data_ff.base_microseconds;
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_pp0_ff  <= (2*HW)'(in_data.elapsed[HW-1:0]) * (2*HW)'(Recip[HW-1:0]);
         s1_pp1_ff  <= (HW+RHW)'(in_data.elapsed[HW-1:0]) * (HW+RHW)'(Recip[QW-1:HW]);
         s1_pp2_ff  <= (2*HW)'(in_data.elapsed[2*HW-1:HW]) * (2*HW)'(Recip[HW-1:0]);
         s1_pp3_ff  <= (HW+RHW)'(in_data.elapsed[2*HW-1:HW]) * (HW+RHW)'(Recip[QW-1:HW]);
         s1_data_ff <= in_data;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_quot_ff <= s2_sum[PW-1:2*HW];
         s2_data_ff <= s1_data_ff;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_prod_ff <= s3_prod[HW-1:0];
         s3_quot_ff <= s2_quot_ff;
         s3_data_ff <= s2_data_ff;
      end
      if (s3_valid_ff && s4_ready) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

// ===== rtl/tctd_usec.sv =====
// ----------------------------------------------------------------------------
// tctd_usec
// tick remainder to whole microseconds by reciprocal multiply and correction
// ----------------------------------------------------------------------------
module tctd_usec #(
   parameter int unsigned TICK_HZ = tctd_pkg::TICK_HZ_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tctd_pkg::split_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tctd_pkg::sub_type    out_data
);

   localparam int unsigned HZW = tctd_pkg::HZ_W;
   localparam int unsigned UW  = tctd_pkg::USEC_W;
   localparam int unsigned SH  = tctd_pkg::USEC_SHIFT;
   localparam int unsigned RW  = SH + 1;
   localparam int unsigned AW  = HZW + RW;
   localparam int unsigned NW  = HZW + UW + 1;
   localparam logic [63:0] UsecRecipFull =
      ((64'd1 << SH) * 64'(tctd_pkg::USEC_PER_SEC)) / 64'(TICK_HZ);
   localparam logic [RW-1:0]  UsecRecip = UsecRecipFull[RW-1:0];
   localparam logic [HZW-1:0] HzVal     = HZW'(TICK_HZ);

   // stage 1: estimate product and scaled remainder
   logic                 s1_valid_ff, s1_valid_in, s1_ready;
   logic [AW-1:0]        s1_est_ff;
   logic [NW-1:0]        s1_scaled_ff;
   tctd_pkg::split_type  s1_data_ff;
   // stage 2: back-multiply of the next microsecond
   logic                 s2_valid_ff, s2_valid_in, s2_ready;
   logic [UW-1:0]        s2_usec;
   logic [UW:0]          s2_usec_next;
   logic [UW-1:0]        s2_usec_ff;
   logic [NW-1:0]        s2_check_ff;
   logic [NW-1:0]        s2_scaled_ff;
   tctd_pkg::split_type  s2_data_ff;
   // stage 3: correction
   logic                 s3_valid_ff, s3_valid_in, s3_ready;
   tctd_pkg::sub_type    s3_data_in;
   tctd_pkg::sub_type    s3_data_ff;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid    : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_comb begin
      s2_usec      = s1_est_ff[SH +: UW];
      s2_usec_next = (UW+1)'(s2_usec) + (UW+1)'(1);
      s3_data_in.quotient          = s2_data_ff.quotient;
      s3_data_in.sub_microseconds  = (s2_check_ff <= s2_scaled_ff)
                                   ? (s2_usec_ff + UW'(1)) : s2_usec_ff;
      s3_data_in.base_seconds      = s2_data_ff.base_seconds;
      s3_data_in.base_microseconds = s2_data_ff.base_microseconds;
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_est_ff    <= AW'(in_data.remainder) * AW'(UsecRecip);
         s1_scaled_ff <= NW'(in_data.remainder) * NW'(tctd_pkg::USEC_PER_SEC);
         s1_data_ff   <= in_data;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_usec_ff   <= s2_usec;
         s2_check_ff  <= NW'(s2_usec_next) * NW'(HzVal);
         s2_scaled_ff <= s1_scaled_ff;
         s2_data_ff   <= s1_data_ff;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

// ===== rtl/tctd_combine.sv =====
// ----------------------------------------------------------------------------
// tctd_combine
// adds elapsed time to the base with microsecond carry, result register
// ----------------------------------------------------------------------------
module tctd_combine (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  tctd_pkg::sub_type  in_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tctd_pkg::rsp_type  rsp_data
);

   localparam int unsigned UW = tctd_pkg::USEC_W;
   localparam int unsigned SW = tctd_pkg::SEC_W;

   logic               valid_ff, valid_in;
   logic [UW:0]        usec_sum;
   logic               carry;
   tctd_pkg::rsp_type  data_in;
   tctd_pkg::rsp_type  data_ff;

   assign in_ready = !valid_ff || !rsp_stall;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      usec_sum = (UW+1)'(in_data.base_microseconds) + (UW+1)'(in_data.sub_microseconds);
      carry    = (usec_sum >= (UW+1)'(tctd_pkg::USEC_PER_SEC));
      data_in.microseconds = carry
                           ? UW'(usec_sum - (UW+1)'(tctd_pkg::USEC_PER_SEC))
                           : usec_sum[UW-1:0];
      data_in.seconds      = in_data.base_seconds + SW'(in_data.quotient) + SW'(carry);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/tick_counter_time_of_day_top.sv =====
// ----------------------------------------------------------------------------
// tick_counter_time_of_day_top
// time of day from a free-running 64-bit tick counter
// ----------------------------------------------------------------------------
// each req transfer carries the counter value and a command. a set stores
// the given seconds and microseconds as the base and the counter value as
// the reference, and returns nothing. a read returns one rsp transfer with
// base plus the ticks elapsed since the reference, in whole microseconds
// at TICK_HZ, microseconds carried into seconds, seconds wrapping at 63 bits.
// a read passes through one capture register, four stages of reciprocal
// divide by the tick rate, three stages of sub-second conversion and the
// result register. one transfer per cycle is taken in steady state while
// rsp_stall stays low. the time is measured against the base in force when
// the read is taken. reset clears base and reference to zero and empties the
// pipeline. while rsp_stall is high the result holds and the pipeline fills
// its empty stages; req_stall rises only once every stage holds a result.
// ----------------------------------------------------------------------------
module tick_counter_time_of_day_top #(
   parameter int unsigned TICK_HZ = tctd_pkg::TICK_HZ_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tctd_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tctd_pkg::rsp_type  rsp_data
);

   logic                   cap_valid, cap_ready;
   tctd_pkg::elapsed_type  cap_data;
   logic                   div_valid, div_ready;
   tctd_pkg::split_type    div_data;
   logic                   usec_valid, usec_ready;
   tctd_pkg::sub_type      usec_data;

   tctd_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_valid (cap_valid),
      .out_ready (cap_ready),
      .out_data  (cap_data)
   );

   tctd_divide #(
      .TICK_HZ (TICK_HZ)
   ) u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cap_valid),
      .in_ready  (cap_ready),
      .in_data   (cap_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   tctd_usec #(
      .TICK_HZ (TICK_HZ)
   ) u_usec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (usec_valid),
      .out_ready (usec_ready),
      .out_data  (usec_data)
   );

   tctd_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (usec_valid),
      .in_ready  (usec_ready),
      .in_data   (usec_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the tick counter time-of-day unit
// ----------------------------------------------------------------------------
// drives set and read commands with counter values and keeps its own model of
// base time and reference count. each read is predicted as the base plus the
// elapsed ticks in whole microseconds, and every rsp transfer is checked
// field by field, in order. directed cases cover reads before any set, the
// conversion edges, counter and seconds wrap and out-of-range microseconds.
// random set-then-read runs follow, first under sender idling and receiver
// stalls, then the reverse, then at full rate.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned TICK_RATE   = tctd_pkg::TICK_HZ_DEFAULT;
   localparam int          CYCLE_LIMIT = 200000;
   localparam logic [63:0] USEC_SCALE  = 64'd1000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   tctd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   tctd_pkg::rsp_type rsp_data;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatch_count     = 0;
   int cycle_count        = 0;

   // model of the unit's state
   logic [62:0]       base_sec   = '0;
   logic [19:0]       base_usec  = '0;
   logic [63:0]       ref_count  = '0;
   tctd_pkg::rsp_type time_of_day_q[$];

   tick_counter_time_of_day_top #(
      .TICK_HZ(TICK_RATE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void predict_time_of_day(input tctd_pkg::req_type r);
      logic [63:0]       elapsed;
      logic [63:0]       whole_sec;
      logic [63:0]       sub_usec;
      logic [63:0]       sec;
      logic [63:0]       usec;
      tctd_pkg::rsp_type t;
      if (r.command == tctd_pkg::CMD_SET) begin
         base_sec  = r.set_seconds;
         base_usec = r.set_microseconds;
         ref_count = r.counter_now;
         return;
      end
      elapsed   = r.counter_now - ref_count;
      whole_sec = elapsed / 64'(TICK_RATE);
      sub_usec  = ((elapsed % 64'(TICK_RATE)) * USEC_SCALE) / 64'(TICK_RATE);
      sec       = {1'b0, base_sec} + whole_sec;
      usec      = {44'd0, base_usec} + sub_usec;
      if (usec >= USEC_SCALE) begin
         usec = usec - USEC_SCALE;
         sec  = sec + 64'd1;
      end
      t.seconds      = sec[62:0];
      t.microseconds = usec[19:0];
      time_of_day_q.push_back(t);
   endfunction

   // called at a falling edge, returns at a falling edge with valid left high
   task automatic send_request(input tctd_pkg::command_type cmd,
                               input logic [63:0] now,
                               input logic [62:0] sec, input logic [19:0] usec);
      tctd_pkg::req_type r;
      r.command          = cmd;
      r.counter_now      = now;
      r.set_seconds      = sec;
      r.set_microseconds = usec;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predict_time_of_day(r);
      @(negedge clock);
   endtask

   task automatic send_read(input logic [63:0] now);
      send_request(tctd_pkg::CMD_READ, now, 63'(rand64()), 20'($urandom));
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      tctd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (time_of_day_q.size() == 0) begin
            $display("%0t: unexpected transfer, actual seconds %0d microseconds %0d",
                     $time, rsp_data.seconds, rsp_data.microseconds);
            mismatch_count++;
         end else begin
            want = time_of_day_q.pop_front();
            if (rsp_data.seconds !== want.seconds) begin
               $display("%0t: seconds mismatch, expected %0d, actual %0d",
                        $time, want.seconds, rsp_data.seconds);
               mismatch_count++;
            end
            if (rsp_data.microseconds !== want.microseconds) begin
               $display("%0t: microseconds mismatch, expected %0d, actual %0d",
                        $time, want.microseconds, rsp_data.microseconds);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tick_counter_time_of_day_top test failed");
         $finish;
      end
   end

   task automatic test_read_before_set();
      send_read(64'd0);
      send_read(64'hFFFF_FFFF_FFFF_FFFF);
      send_read(64'(TICK_RATE) - 64'd1);
   endtask

   task automatic test_sub_second_conversion();
      send_request(tctd_pkg::CMD_SET, 64'd1000, 63'd0, 20'd0);
      send_read(64'd1000);
      send_read(64'd1000 + 64'd23);
      send_read(64'd1000 + 64'd24);
      send_read(64'd1000 + 64'(TICK_RATE) - 64'd1);
      send_read(64'd1000 + 64'(TICK_RATE));
   endtask

   task automatic test_counter_and_seconds_wrap();
      send_request(tctd_pkg::CMD_SET, 64'hFFFF_FFFF_FFFF_FFFB, 63'h7FFF_FFFF_FFFF_FFFF,
                   20'd999999);
      send_read(64'hFFFF_FFFF_FFFF_FFFB);
      send_read(64'd3);
      send_read(64'hFFFF_FFFF_FFFF_FFFB + 64'd24);
      send_read(64'hFFFF_FFFF_FFFF_FFFA);
   endtask

   task automatic test_out_of_range_microseconds();
      send_request(tctd_pkg::CMD_SET, 64'h5555_5555_5555_5555, 63'd12345, 20'hFFFFF);
      send_read(64'h5555_5555_5555_5555);
      send_read(64'h5555_5555_5555_5555 + 64'(TICK_RATE) - 64'd1);
      send_request(tctd_pkg::CMD_SET, 64'hAAAA_AAAA_AAAA_AAAA, 63'h7FFF_FFFF_FFFF_FFFF,
                   20'd1000000);
      send_read(64'hAAAA_AAAA_AAAA_AAAA + 64'(TICK_RATE) * 64'd7 + 64'd12);
   endtask

   task automatic test_random_time_sequences(input int n_items);
      int          sent;
      int          reads;
      logic [63:0] now;
      logic [63:0] delta;
      logic [62:0] sec;
      logic [19:0] usec;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            // unrelated traffic: any command, any counter
            send_request(tctd_pkg::command_type'($urandom_range(1)), rand64(),
                         63'(rand64()), 20'($urandom));
            sent++;
         end else begin
            now  = rand64();
            case ($urandom_range(3))
               0: sec = 63'h7FFF_FFFF_FFFF_FFFF - 63'($urandom_range(1000));
               1: sec = 63'($urandom_range(100000));
               default: sec = 63'(rand64());
            endcase
            if ($urandom_range(7) == 0)
               usec = 20'($urandom);
            else
               usec = 20'($urandom_range(999999));
            if ($urandom_range(5) == 0)
               now = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(100000000));
            send_request(tctd_pkg::CMD_SET, now, sec, usec);
            sent++;
            reads = $urandom_range(8, 1);
            repeat (reads) begin
               case ($urandom_range(3))
                  0: delta = 64'($urandom_range(3 * TICK_RATE));
                  1: delta = {24'd0, 8'($urandom), $urandom};
                  2: delta = rand64();
                  default: delta = 64'(TICK_RATE) * 64'($urandom_range(100000))
                                   + 64'($urandom_range(47));
               endcase
               now = now + delta;
               send_read(now);
               sent++;
            end
         end
      end
   endtask

   initial begin
      sender_idle_pct    = 25;
      receiver_stall_pct = 67;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_read_before_set();
      test_sub_second_conversion();
      test_counter_and_seconds_wrap();
      test_out_of_range_microseconds();

      test_random_time_sequences(360);
      sender_idle_pct    = 67;
      receiver_stall_pct = 25;
      test_random_time_sequences(360);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      test_random_time_sequences(360);

      req_valid <= 1'b0;
      while (time_of_day_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0)
         $display("tick_counter_time_of_day_top test passed");
      else
         $display("tick_counter_time_of_day_top test failed");
      $finish;
   end

endmodule
